// ----- design/prj_pkg.sv -----
// Shared types and constants for the pose reprojection Jacobian block.
package prj_pkg;

    localparam int CoordW  = 32;
    localparam int FocalW  = CoordW - 1;
    // start to done: input register, three multiply/add stages, divider, output register
    localparam int Latency = CoordW + 6;

    typedef enum logic [0:0] {
        CFG_FOCAL_X = 1'b0,
        CFG_FOCAL_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [CoordW-1:0] u_dphi_x;
        logic signed [CoordW-1:0] u_dphi_y;
        logic signed [CoordW-1:0] u_dphi_z;
        logic signed [CoordW-1:0] u_dt_x;
        logic signed [CoordW-1:0] u_dt_z;
        logic signed [CoordW-1:0] v_dphi_x;
        logic signed [CoordW-1:0] v_dphi_y;
        logic signed [CoordW-1:0] v_dphi_z;
        logic signed [CoordW-1:0] v_dt_y;
        logic signed [CoordW-1:0] v_dt_z;
        logic                     depth_invalid;
    } jac_t;

endpackage

// ----- design/pose_reprojection_jacobian.sv -----
// Top level: pinhole projection Jacobian for a left SE3 pose perturbation.
//
// One camera-frame point (Q16.16) enters per transfer and the ten nonzero
// entries of the 2x6 reprojection Jacobian leave, each rounded once to
// nearest (ties away from zero) and saturated. A transfer is taken on every
// cycle with start high; busy is always low, so a new point may follow in the
// very next cycle. Each result shows on jacobian for exactly one cycle with
// done high once its point has passed the full pipeline; results
// leave in the order points came in, and the receiver must take them then.
// The latency is set by the exact dividers, which resolve one quotient bit
// per pipeline stage; ahead of them sit an input register and three stages of
// 32x32 multiplies and numerator adds. A point with zero or negative depth
// gives depth_invalid high and all entries zero. Write focal_x / focal_y
// through cfg_wr_en only while no result is outstanding.
module pose_reprojection_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  prj_pkg::point_t            point,
    input  logic                       cfg_wr_en,
    input  prj_pkg::cfg_reg_t          cfg_index,
    input  logic [prj_pkg::FocalW-1:0] cfg_data,
    output logic                       done,
    output prj_pkg::jac_t              jacobian
);

    import prj_pkg::*;

    localparam int W  = CoordW;
    localparam int PD = 4 + W + 1;   // stages ahead of the output register

    typedef struct packed {
        logic valid;
        logic xn;
        logic yn;
        logic inv;
    } ctl_t;

    logic [FocalW-1:0] focal_x_reg, focal_y_reg;
    ctl_t              ctl_reg [0:PD-1];

    // stage 1: magnitudes
    logic [W-1:0] xm_reg, ym_reg, zm_reg;
    // stage 2: products
    logic [2*W-1:0] xy_reg, xx_reg, yy_reg, zz_reg;
    logic [2*W-1:0] fxx_reg, fxy_reg, fyx_reg, fyy_reg;
    logic [W-1:0]   zm2_reg;
    // stage 3: focal times squared terms, split in halves
    logic [2*W-1:0] fx_xy_lo_reg, fx_xy_hi_reg, fx_xx_lo_reg, fx_xx_hi_reg;
    logic [2*W-1:0] fy_yy_lo_reg, fy_yy_hi_reg, fy_xy_lo_reg, fy_xy_hi_reg;
    logic [2*W-1:0] zz3_reg, fxx3_reg, fxy3_reg, fyx3_reg, fyy3_reg;
    logic [W-1:0]   zm3_reg;
    // stage 4: rounded numerators and denominators
    logic [3*W-1:0] num2_reg [0:5];
    logic [2*W-1:0] num1_reg [0:3];
    logic [2*W-1:0] zz4_reg;
    logic [W-1:0]   zm4_reg;

    logic [W-1:0] q2 [0:5];
    logic         o2 [0:5];
    logic [W-1:0] q1 [0:3];
    logic         o1 [0:3];

    logic         done_reg;
    jac_t         jac_reg, jac_next;
    ctl_t         ctl_out;

    // Focal registers: plain writes, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg <= FocalW'(32768000);
            focal_y_reg <= FocalW'(32768000);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FOCAL_X: focal_x_reg <= cfg_data;
                CFG_FOCAL_Y: focal_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Control travels alongside the data; nothing stalls, so just advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PD; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= '{valid: start,
                            xn:    point.point_x[W-1],
                            yn:    point.point_y[W-1],
                            inv:   point.point_z[W-1] || (point.point_z == '0)};
            for (int k = 1; k < PD; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Stage 1: take magnitudes of the signed coordinates.
    always_ff @(posedge clk)
    begin
        xm_reg <= point.point_x[W-1] ? W'(-point.point_x) : W'(point.point_x);
        ym_reg <= point.point_y[W-1] ? W'(-point.point_y) : W'(point.point_y);
        zm_reg <= point.point_z[W-1] ? W'(-point.point_z) : W'(point.point_z);
    end

    // Stage 2: one multiply per product.
    always_ff @(posedge clk)
    begin
        xy_reg  <= (2*W)'(xm_reg) * (2*W)'(ym_reg);
        xx_reg  <= (2*W)'(xm_reg) * (2*W)'(xm_reg);
        yy_reg  <= (2*W)'(ym_reg) * (2*W)'(ym_reg);
        zz_reg  <= (2*W)'(zm_reg) * (2*W)'(zm_reg);
        fxx_reg <= (2*W)'(focal_x_reg) * (2*W)'(xm_reg);
        fxy_reg <= (2*W)'(focal_x_reg) * (2*W)'(ym_reg);
        fyx_reg <= (2*W)'(focal_y_reg) * (2*W)'(xm_reg);
        fyy_reg <= (2*W)'(focal_y_reg) * (2*W)'(ym_reg);
        zm2_reg <= zm_reg;
    end

    // Stage 3: focal length times each half of the double-width squares.
    always_ff @(posedge clk)
    begin
        fx_xy_lo_reg <= (2*W)'(focal_x_reg) * (2*W)'(xy_reg[W-1:0]);
        fx_xy_hi_reg <= (2*W)'(focal_x_reg) * (2*W)'(xy_reg[2*W-1:W]);
        fx_xx_lo_reg <= (2*W)'(focal_x_reg) * (2*W)'(xx_reg[W-1:0]);
        fx_xx_hi_reg <= (2*W)'(focal_x_reg) * (2*W)'(xx_reg[2*W-1:W]);
        fy_yy_lo_reg <= (2*W)'(focal_y_reg) * (2*W)'(yy_reg[W-1:0]);
        fy_yy_hi_reg <= (2*W)'(focal_y_reg) * (2*W)'(yy_reg[2*W-1:W]);
        fy_xy_lo_reg <= (2*W)'(focal_y_reg) * (2*W)'(xy_reg[W-1:0]);
        fy_xy_hi_reg <= (2*W)'(focal_y_reg) * (2*W)'(xy_reg[2*W-1:W]);
        zz3_reg  <= zz_reg;
        zm3_reg  <= zm2_reg;
        fxx3_reg <= fxx_reg;
        fxy3_reg <= fxy_reg;
        fyx3_reg <= fyx_reg;
        fyy3_reg <= fyy_reg;
    end

    // Stage 4: join the halves and add half the divisor for round-to-nearest.
    always_ff @(posedge clk)
    begin
        num2_reg[0] <= ((3*W)'(fx_xy_hi_reg) << W) + (3*W)'(fx_xy_lo_reg)
                       + (3*W)'(zz3_reg >> 1);
        num2_reg[1] <= ((3*W)'(fx_xx_hi_reg) << W) + (3*W)'(fx_xx_lo_reg)
                       + (3*W)'(zz3_reg >> 1);
        num2_reg[2] <= ((3*W)'(fxx3_reg) << FRAC_BITS) + (3*W)'(zz3_reg >> 1);
        num2_reg[3] <= ((3*W)'(fy_yy_hi_reg) << W) + (3*W)'(fy_yy_lo_reg)
                       + (3*W)'(zz3_reg >> 1);
        num2_reg[4] <= ((3*W)'(fy_xy_hi_reg) << W) + (3*W)'(fy_xy_lo_reg)
                       + (3*W)'(zz3_reg >> 1);
        num2_reg[5] <= ((3*W)'(fyy3_reg) << FRAC_BITS) + (3*W)'(zz3_reg >> 1);
        num1_reg[0] <= fxy3_reg + (2*W)'(zm3_reg >> 1);
        num1_reg[1] <= ((2*W)'(focal_x_reg) << FRAC_BITS) + (2*W)'(zm3_reg >> 1);
        num1_reg[2] <= fyx3_reg + (2*W)'(zm3_reg >> 1);
        num1_reg[3] <= ((2*W)'(focal_y_reg) << FRAC_BITS) + (2*W)'(zm3_reg >> 1);
        zz4_reg <= zz3_reg;
        zm4_reg <= zm3_reg;
    end

    // Divisions by Z^2.
    for (genvar i = 0; i < 6; i++)
    begin : g_div_zz
        prj_div #(.DEN_W(2*W), .Q_W(W)) u_div (
            .clk (clk),
            .num (num2_reg[i]),
            .den (zz4_reg),
            .quo (q2[i]),
            .ovf (o2[i])
        );
    end

    // Divisions by Z.
    for (genvar i = 0; i < 4; i++)
    begin : g_div_z
        prj_div #(.DEN_W(W), .Q_W(W)) u_div (
            .clk (clk),
            .num (num1_reg[i]),
            .den (zm4_reg),
            .quo (q1[i]),
            .ovf (o1[i])
        );
    end

    // Clamp a magnitude to the signed range, then apply the sign.
    function automatic logic [W-1:0] sat_mag(input logic [W:0] mag,
                                             input logic ovf,
                                             input logic neg);
        logic [W:0]   limit;
        logic [W-1:0] m;
        limit = {1'b0, neg, {(W-1){!neg}}};
        m = (ovf || (mag > limit)) ? limit[W-1:0] : mag[W-1:0];
        return neg ? W'(-m) : m;
    endfunction

    assign ctl_out = ctl_reg[PD-1];

    always_comb
    begin
        jac_next = '0;
        if (ctl_out.inv)
        begin
            jac_next.depth_invalid = 1'b1;
        end
        else
        begin
            jac_next.u_dphi_x = sat_mag({1'b0, q2[0]}, o2[0], !(ctl_out.xn ^ ctl_out.yn));
            // 1 + X^2/Z^2 term: integer focal part plus rounded fraction
            jac_next.u_dphi_y = sat_mag((W+1)'(focal_x_reg) + (W+1)'(q2[1]), o2[1], 1'b0);
            jac_next.u_dphi_z = sat_mag({1'b0, q1[0]}, o1[0], !ctl_out.yn);
            jac_next.u_dt_x   = sat_mag({1'b0, q1[1]}, o1[1], 1'b0);
            jac_next.u_dt_z   = sat_mag({1'b0, q2[2]}, o2[2], !ctl_out.xn);
            jac_next.v_dphi_x = sat_mag((W+1)'(focal_y_reg) + (W+1)'(q2[3]), o2[3], 1'b1);
            jac_next.v_dphi_y = sat_mag({1'b0, q2[4]}, o2[4], ctl_out.xn ^ ctl_out.yn);
            jac_next.v_dphi_z = sat_mag({1'b0, q1[2]}, o1[2], ctl_out.xn);
            jac_next.v_dt_y   = sat_mag({1'b0, q1[3]}, o1[3], 1'b0);
            jac_next.v_dt_z   = sat_mag({1'b0, q2[5]}, o2[5], !ctl_out.yn);
        end
    end

    // Output register: strobe for one cycle per result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        jac_reg <= jac_next;
    end

    // Fully pipelined: a transfer is taken on every cycle.
    assign busy     = 1'b0;
    assign done     = done_reg;
    assign jacobian = jac_reg;

endmodule

// ----- design/prj_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, overflow flag.
module prj_div #(
    parameter int DEN_W = 64,
    parameter int Q_W   = 32
) (
    input  logic                   clk,
    input  logic [DEN_W+Q_W-1:0]   num,
    input  logic [DEN_W-1:0]       den,
    output logic [Q_W-1:0]         quo,
    output logic                   ovf
);

    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic [DEN_W-1:0] rem_reg [0:Q_W];
    logic [Q_W-1:0]   low_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ovf_reg [0:Q_W];

    // Quotient at or above 2^Q_W: flag it, the rest of the bits are don't-care.
    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        rem_reg[0] <= num[DEN_W+Q_W-1:Q_W];
        low_reg[0] <= num[Q_W-1:0];
        q_reg[0]   <= '0;
        ovf_reg[0] <= (num[DEN_W+Q_W-1:Q_W] >= den);
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             take;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
            diff  = {1'b0, trial} - {2'b00, den_reg[k-1]};
            take  = !diff[DEN_W+1];
        end

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg[k] <= low_reg[k-1] << 1;
            q_reg[k]   <= {q_reg[k-1][Q_W-2:0], take};
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign quo = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

// ----- design/prj_checker.sv -----
// Port-level checker for the pose reprojection Jacobian block, with its bind.
module prj_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input prj_pkg::jac_t jacobian
);

    import prj_pkg::*;

    // Every accepted point produces a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##Latency done)
        else $error("result missing after accepted transfer");

    // No result without a point accepted the fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Latency))
        else $error("result without matching transfer");

    // Invalid depth drives every entry to zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && jacobian.depth_invalid |->
            jacobian.u_dphi_x == '0 && jacobian.u_dphi_y == '0 &&
            jacobian.u_dphi_z == '0 && jacobian.u_dt_x == '0 &&
            jacobian.u_dt_z == '0 && jacobian.v_dphi_x == '0 &&
            jacobian.v_dphi_y == '0 && jacobian.v_dphi_z == '0 &&
            jacobian.v_dt_y == '0 && jacobian.v_dt_z == '0)
        else $error("nonzero entry with invalid depth");

    // Sign-definite entries: fx/Z, fy/Z, fx(1+..) never negative; -fy(1+..) never positive.
    a_signs: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !jacobian.u_dt_x[CoordW-1] && !jacobian.v_dt_y[CoordW-1] &&
                 !jacobian.u_dphi_y[CoordW-1] &&
                 (jacobian.v_dphi_x[CoordW-1] || jacobian.v_dphi_x == '0))
        else $error("sign-definite entry has wrong sign");

endmodule

bind pose_reprojection_jacobian prj_checker u_prj_checker (.*);
